// File: src/mnr_pkg.sv
`default_nettype none

package mnr_pkg;

	// Sizing of the particle set and of the weights.
	localparam int PARTICLE_COUNT = 256;
	localparam int WEIGHT_BITS    = 16;

	// Fixed widths of the request and result fields.
	localparam int OP_BITS      = 2;
	localparam int IN_WT_BITS   = 16;
	localparam int RAND_BITS    = 16;
	localparam int POS_BITS     = 8;
	localparam int OUT_IDX_BITS = 8;
	localparam int NORM_BITS    = 16;
	localparam int STATUS_BITS  = 2;

	// Fixed-point full scale: 65535 stands for one.
	localparam int SCALE_BITS = 16;
	localparam int FULL_SCALE = (1 << SCALE_BITS) - 1;

	// Derived widths.
	localparam int IDX_BITS      = $clog2(PARTICLE_COUNT);
	localparam int CNT_BITS      = $clog2(PARTICLE_COUNT + 1);
	localparam int SUM_BITS      = WEIGHT_BITS + IDX_BITS;
	localparam int PROD_BITS     = RAND_BITS + SUM_BITS;
	localparam int DIVIDEND_BITS = WEIGHT_BITS + SCALE_BITS;

	// Operation carried by a request. The last code is unused and gives an
	// all-zero result without touching any state.
	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD  = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	// Status carried by a result.
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_FULL = 2'd2
	} status_t;

endpackage

`default_nettype wire

// File: src/mnr_pick.sv
`default_nettype none

module mnr_pick (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [mnr_pkg::RAND_BITS-1:0] rand_val,
	input  wire logic [mnr_pkg::SUM_BITS-1:0]  total,
	output logic                              done,
	output logic [mnr_pkg::SUM_BITS-1:0]      pick
);
	import mnr_pkg::*;

	localparam int ACC_BITS = PROD_BITS + 1;

	logic                 valid_s1, valid_s2, valid_s3;
	logic [PROD_BITS-1:0] x_s1, x_s2;
	logic [SUM_BITS-1:0]  est_s2;
	logic [SUM_BITS-1:0]  pick_s3;
	logic [ACC_BITS-1:0]  acc;
	logic [ACC_BITS-1:0]  est_scaled;
	logic [ACC_BITS-1:0]  rem;
	logic                 bump;

	// x / 65535 is x / 2^16 * (1 + 2^-16 + 2^-32 + ...). The truncated series
	// lands on the true quotient or one below it; the remainder check fixes that.
	assign acc = ACC_BITS'(x_s1) + ACC_BITS'(x_s1 >> SCALE_BITS)
		+ ACC_BITS'(x_s1 >> (2 * SCALE_BITS));

	assign est_scaled = (ACC_BITS'(est_s2) << SCALE_BITS) - ACC_BITS'(est_s2);
	assign rem        = ACC_BITS'(x_s2) - est_scaled;
	assign bump       = (rem >= ACC_BITS'(FULL_SCALE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= PROD_BITS'(rand_val) * PROD_BITS'(total);
		x_s2    <= x_s1;
		est_s2  <= SUM_BITS'(acc >> SCALE_BITS);
		pick_s3 <= est_s2 + SUM_BITS'(bump);
	end

	assign done = valid_s3;
	assign pick = pick_s3;

endmodule

`default_nettype wire

// File: src/mnr_divider.sv
`default_nettype none

module mnr_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [mnr_pkg::DIVIDEND_BITS-1:0] dividend,
	input  wire logic [mnr_pkg::SUM_BITS-1:0]      divisor,
	output logic                                   done,
	output logic [mnr_pkg::SCALE_BITS-1:0]         quotient
);
	import mnr_pkg::*;

	localparam int STEP_BITS = $clog2(SCALE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_BITS-1:0]  count_q;
	logic [SUM_BITS-1:0]   rem_q;
	logic [SUM_BITS-1:0]   dvs_q;
	logic [SCALE_BITS-1:0] low_q;
	logic [SUM_BITS:0]     trial;
	logic                  fits;

	// The caller guarantees the quotient fits in SCALE_BITS, so the high part
	// of the dividend starts out below the divisor and only the low bits step.
	assign trial = {rem_q, low_q[SCALE_BITS-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= STEP_BITS'(SCALE_BITS);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SUM_BITS'(dividend >> SCALE_BITS);
			low_q <= dividend[SCALE_BITS-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= SUM_BITS'(fits ? trial - {1'b0, dvs_q} : trial);
			low_q <= {low_q[SCALE_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

`default_nettype wire

// File: src/multinomial_resampler_unit.sv
`default_nettype none

// Multinomial resampler for a particle filter, 16-bit unsigned fixed point.
// Each request carries an operation: load appends a weight and stores the
// running cumulative sum (a load after any successful draw starts a new set),
// draw scales a uniform random value to the loaded total, binary-searches the
// cumulative store for the first entry at or above that pick and records the
// chosen particle's weight, and read returns a recorded weight times 65535
// divided by the sum of recorded weights. Every request yields exactly one
// result, carrying status 0 for success, 1 for a zero total or zero sum, and
// 2 for a full table or a slot not yet drawn. The unit works on one request at
// a time, but the result sits in an output register, so the next request is
// taken while an earlier result still waits. A draw runs k search steps,
// where k is at most ceil(log2(particles loaded)): each step issues one
// read of the cumulative memory and compares the registered data in the
// following cycle, and the pick itself comes from a three-stage multiply
// and constant scaling pipeline. A read forms the normalized weight in the
// 16-step serial divider. Both memories power up undefined and only data
// from entries that the current set has written is ever used, so no
// clearing pass is needed after reset.
module multinomial_resampler_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire logic [mnr_pkg::OP_BITS-1:0]     operation,
	input  wire logic [mnr_pkg::IN_WT_BITS-1:0]  weight_in,
	input  wire logic [mnr_pkg::RAND_BITS-1:0]   random_value,
	input  wire logic [mnr_pkg::POS_BITS-1:0]    position,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic [mnr_pkg::OUT_IDX_BITS-1:0]     source_index,
	output logic [mnr_pkg::NORM_BITS-1:0]        normalized_weight,
	output logic [mnr_pkg::STATUS_BITS-1:0]      status
);
	import mnr_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE       = 10'b00_0000_0001,
		S_DECODE     = 10'b00_0000_0010,
		S_PICK       = 10'b00_0000_0100,
		S_SEARCH_RD  = 10'b00_0000_1000,
		S_SEARCH_CMP = 10'b00_0001_0000,
		S_FETCH      = 10'b00_0010_0000,
		S_CHOSEN     = 10'b00_0100_0000,
		S_SEL_RD     = 10'b00_1000_0000,
		S_DIV        = 10'b01_0000_0000,
		S_FINISH     = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Captured request.
	logic [OP_BITS-1:0]     op_q;
	logic [WEIGHT_BITS-1:0] wt_q;
	logic [RAND_BITS-1:0]   rand_q;
	logic [POS_BITS-1:0]    pos_q;

	// Set bookkeeping.
	logic [CNT_BITS-1:0] loaded_q;
	logic [CNT_BITS-1:0] drawn_q;
	logic [SUM_BITS-1:0] total_q;
	logic [SUM_BITS-1:0] sum_q;

	// Search registers.
	logic [SUM_BITS-1:0] pick_q;
	logic [IDX_BITS-1:0] lo_q, hi_q, mid_q;

	// Pending result and output register.
	logic [OUT_IDX_BITS-1:0] res_idx_q;
	logic [NORM_BITS-1:0]    res_norm_q;
	logic [STATUS_BITS-1:0]  res_status_q;
	logic                    out_valid_q;
	logic [OUT_IDX_BITS-1:0] out_idx_q;
	logic [NORM_BITS-1:0]    out_norm_q;
	logic [STATUS_BITS-1:0]  out_status_q;

	// Cumulative weight memory: one write port, two read ports.
	logic [SUM_BITS-1:0] cum_mem [PARTICLE_COUNT];
	logic                cum_we;
	logic [IDX_BITS-1:0] cum_waddr;
	logic [SUM_BITS-1:0] cum_wdata;
	logic                cum_re;
	logic [IDX_BITS-1:0] cum_ra, cum_rb;
	logic [SUM_BITS-1:0] cum_rd_a_q, cum_rd_b_q;

	// Selected weight memory: one write port, one read port.
	logic [WEIGHT_BITS-1:0] sel_mem [PARTICLE_COUNT];
	logic                   sel_we;
	logic [IDX_BITS-1:0]    sel_waddr;
	logic [WEIGHT_BITS-1:0] sel_wdata;
	logic                   sel_re;
	logic [IDX_BITS-1:0]    sel_ra;
	logic [WEIGHT_BITS-1:0] sel_rd_q;

	// Decode of the captured request.
	logic                accept;
	logic                out_free;
	logic                new_set;
	logic                load_full;
	logic                draw_zero;
	logic                draw_full;
	logic                read_bad_pos;
	logic                read_zero;
	logic [IDX_BITS-1:0] mid_next;
	logic [SUM_BITS-1:0] chosen;

	// Scaling pipeline and divider hookups.
	logic                     pick_start;
	logic                     pick_done;
	logic [SUM_BITS-1:0]      pick_val;
	logic                     div_start;
	logic                     div_done;
	logic [SCALE_BITS-1:0]    div_quot;
	logic [DIVIDEND_BITS-1:0] div_dividend;

	assign accept   = item_valid && !item_stall;
	assign out_free = !out_valid_q || !result_stall;

	assign new_set      = (drawn_q != '0);
	assign load_full    = !new_set && (loaded_q == CNT_BITS'(PARTICLE_COUNT));
	assign draw_zero    = (total_q == '0);
	assign draw_full    = (drawn_q == CNT_BITS'(PARTICLE_COUNT));
	assign read_bad_pos = (32'(pos_q) >= 32'(drawn_q)) || (32'(pos_q) >= 32'(PARTICLE_COUNT));
	assign read_zero    = (sum_q == '0);

	assign mid_next = lo_q + ((hi_q - lo_q) >> 1);
	// Weight of particle j is its prefix sum minus the one before it.
	assign chosen   = cum_rd_a_q - ((lo_q != '0) ? cum_rd_b_q : '0);

	// w * 65535 as a shift and a subtract.
	assign div_dividend = (DIVIDEND_BITS'(sel_rd_q) << SCALE_BITS) - DIVIDEND_BITS'(sel_rd_q);

	always_comb begin
		cum_we     = 1'b0;
		cum_waddr  = new_set ? '0 : loaded_q[IDX_BITS-1:0];
		cum_wdata  = (new_set ? '0 : total_q) + SUM_BITS'(wt_q);
		cum_re     = 1'b0;
		cum_ra     = mid_next;
		cum_rb     = lo_q - 1'b1;
		sel_we     = 1'b0;
		sel_waddr  = drawn_q[IDX_BITS-1:0];
		sel_wdata  = WEIGHT_BITS'(chosen);
		sel_re     = 1'b0;
		sel_ra     = IDX_BITS'(pos_q);
		pick_start = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			S_DECODE: begin
				case (op_q)
					OP_LOAD: cum_we = !load_full;
					OP_DRAW: pick_start = !draw_zero && !draw_full;
					OP_READ: sel_re = !read_bad_pos && !read_zero;
					default: ;
				endcase
			end
			S_SEARCH_RD: begin
				cum_re = (lo_q < hi_q);
			end
			S_FETCH: begin
				cum_re = 1'b1;
				cum_ra = lo_q;
			end
			S_CHOSEN: begin
				sel_we = 1'b1;
			end
			S_SEL_RD: begin
				div_start = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cum_we) begin
			cum_mem[cum_waddr] <= cum_wdata;
		end
		if (cum_re) begin
			cum_rd_a_q <= cum_mem[cum_ra];
			cum_rd_b_q <= cum_mem[cum_rb];
		end
	end

	always_ff @(posedge clk) begin
		if (sel_we) begin
			sel_mem[sel_waddr] <= sel_wdata;
		end
		if (sel_re) begin
			sel_rd_q <= sel_mem[sel_ra];
		end
	end

	mnr_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pick_start),
		.rand_val (rand_q),
		.total    (total_q),
		.done     (pick_done),
		.pick     (pick_val)
	);

	mnr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer and set bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			drawn_q     <= '0;
			total_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FINISH;
					case (op_q)
						OP_LOAD: begin
							if (!load_full) begin
								total_q  <= cum_wdata;
								loaded_q <= (new_set ? '0 : loaded_q) + 1'b1;
								if (new_set) begin
									drawn_q <= '0;
									sum_q   <= '0;
								end
							end
						end
						OP_DRAW: begin
							if (!draw_zero && !draw_full) begin
								state_q <= S_PICK;
							end
						end
						OP_READ: begin
							if (!read_bad_pos && !read_zero) begin
								state_q <= S_SEL_RD;
							end
						end
						default: ;
					endcase
				end
				S_PICK: begin
					if (pick_done) begin
						state_q <= S_SEARCH_RD;
					end
				end
				S_SEARCH_RD: begin
					state_q <= (lo_q < hi_q) ? S_SEARCH_CMP : S_FETCH;
				end
				S_SEARCH_CMP: begin
					state_q <= S_SEARCH_RD;
				end
				S_FETCH: begin
					state_q <= S_CHOSEN;
				end
				S_CHOSEN: begin
					sum_q   <= sum_q + chosen;
					drawn_q <= drawn_q + 1'b1;
					state_q <= S_FINISH;
				end
				S_SEL_RD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: captured request, search bounds and results.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			wt_q   <= WEIGHT_BITS'(weight_in);
			rand_q <= random_value;
			pos_q  <= position;
		end

		case (state_q)
			S_DECODE: begin
				res_idx_q    <= '0;
				res_norm_q   <= '0;
				res_status_q <= ST_OK;
				case (op_q)
					OP_LOAD: begin
						if (load_full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_idx_q <= OUT_IDX_BITS'(cum_waddr);
						end
					end
					OP_DRAW: begin
						if (draw_zero) begin
							res_status_q <= ST_ZERO;
						end else if (draw_full) begin
							res_status_q <= ST_FULL;
						end
					end
					OP_READ: begin
						if (read_bad_pos) begin
							res_status_q <= ST_FULL;
						end else if (read_zero) begin
							res_status_q <= ST_ZERO;
						end
					end
					default: ;
				endcase
			end
			S_PICK: begin
				pick_q <= pick_val;
				lo_q   <= '0;
				hi_q   <= IDX_BITS'(loaded_q - 1'b1);
			end
			S_SEARCH_RD: begin
				mid_q <= mid_next;
			end
			S_SEARCH_CMP: begin
				if (cum_rd_a_q >= pick_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + 1'b1;
				end
			end
			S_CHOSEN: begin
				res_idx_q <= OUT_IDX_BITS'(lo_q);
			end
			S_DIV: begin
				res_norm_q <= NORM_BITS'(div_quot);
			end
			S_FINISH: begin
				if (out_free) begin
					out_idx_q    <= res_idx_q;
					out_norm_q   <= res_norm_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign item_stall        = (state_q != S_IDLE);
	assign result_valid      = out_valid_q;
	assign source_index      = out_idx_q;
	assign normalized_weight = out_norm_q;
	assign status            = out_status_q;

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DECODE))
		else $error("accepted request did not move to decode");

	a_drawn_needs_total: assert property (@(posedge clk) disable iff (!arst_n)
		(drawn_q != '0) |-> ((total_q != '0) && (loaded_q != '0)))
		else $error("draws recorded against an empty or zero set");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(loaded_q <= CNT_BITS'(PARTICLE_COUNT)) && (drawn_q <= CNT_BITS'(PARTICLE_COUNT)))
		else $error("particle counter beyond table size");

	a_prefix_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CHOSEN) && (lo_q != '0)) |-> (cum_rd_a_q >= cum_rd_b_q))
		else $error("cumulative weights read out of order");

	a_weight_within_sum: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (SUM_BITS'(sel_rd_q) <= sum_q))
		else $error("recorded weight exceeds selected sum");

endmodule

`default_nettype wire

// File: tb/sv/tb_multinomial_resampler_unit.sv
`timescale 1ns / 1ps

module tb_multinomial_resampler_unit;

	import mnr_pkg::*;

	// One result as it leaves the unit.
	typedef struct packed {
		logic [OUT_IDX_BITS-1:0] idx;
		logic [NORM_BITS-1:0]    norm;
		logic [STATUS_BITS-1:0]  st;
	} outcome_t;

	// One row of the directed plan. When hand_checked is set, the row carries
	// its expected result; otherwise the predictor supplies it.
	typedef struct packed {
		op_t                   op;
		logic [IN_WT_BITS-1:0] weight;
		logic [RAND_BITS-1:0]  rnd;
		logic [POS_BITS-1:0]   pos;
		logic                  hand_checked;
		outcome_t              want;
	} plan_row_t;

	localparam outcome_t FROM_MODEL = '0;
	localparam int PLAN_ROWS = 24;
	localparam int USEFUL_TARGET = 1200;
	localparam int HOLD_OFF_AT = 400;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [IN_WT_BITS-1:0] WEIGHT_MASK =
		IN_WT_BITS'((64'(1) << WEIGHT_BITS) - 1);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [OP_BITS-1:0] operation = '0;
	logic [IN_WT_BITS-1:0] weight_in = '0;
	logic [RAND_BITS-1:0] random_value = '0;
	logic [POS_BITS-1:0] position = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [OUT_IDX_BITS-1:0] source_index;
	logic [NORM_BITS-1:0] normalized_weight;
	logic [STATUS_BITS-1:0] status;

	always #4 clk = ~clk;

	multinomial_resampler_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.operation         (operation),
		.weight_in         (weight_in),
		.random_value      (random_value),
		.position          (position),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.source_index      (source_index),
		.normalized_weight (normalized_weight),
		.status            (status)
	);

	// Shadow state of the resampler. prefix_sum holds the running cumulative
	// weights of the current set, picked_weight the weights chosen by draws.
	bit [SUM_BITS-1:0]  prefix_sum [PARTICLE_COUNT];
	bit [WEIGHT_BITS-1:0] picked_weight [PARTICLE_COUNT];
	bit [CNT_BITS-1:0]  loads_held;
	bit [CNT_BITS-1:0]  draws_held;
	bit [SUM_BITS-1:0]  picked_sum;

	// Results that the unit still owes, oldest first.
	outcome_t pending_outcomes [$];

	int fail_count = 0;
	int requests_taken = 0;
	int useful_sent = 0;
	int burst_left = 0;

	// Computes the result of one request and advances the shadow state.
	function automatic outcome_t predict_resample(op_t op, logic [IN_WT_BITS-1:0] weight,
			logic [RAND_BITS-1:0] rnd, logic [POS_BITS-1:0] pos);
		outcome_t res;
		bit [SUM_BITS-1:0] total;
		bit [SUM_BITS-1:0] below;
		bit [63:0] pick;
		bit [63:0] quot;
		int slot;
		res = '0;
		case (op)
			OP_LOAD: begin
				// A load after any successful draw opens a fresh set.
				if (draws_held != 0) begin
					loads_held = '0;
					draws_held = '0;
					picked_sum = '0;
				end
				if (loads_held >= PARTICLE_COUNT) begin
					res.st = ST_FULL;
				end else begin
					below = (loads_held != 0) ? prefix_sum[loads_held - 1] : '0;
					prefix_sum[loads_held] = below + SUM_BITS'(weight & WEIGHT_MASK);
					res.idx = loads_held[OUT_IDX_BITS-1:0];
					loads_held++;
				end
			end
			OP_DRAW: begin
				total = (loads_held != 0) ? prefix_sum[loads_held - 1] : '0;
				if (total == 0) begin
					res.st = ST_ZERO;
				end else if (draws_held >= PARTICLE_COUNT) begin
					res.st = ST_FULL;
				end else begin
					// The prefix sums never decrease and the pick never exceeds the
					// total, so a forward scan finds the first entry at or above it.
					pick = (64'(rnd) * 64'(total)) / FULL_SCALE;
					slot = 0;
					while (64'(prefix_sum[slot]) < pick)
						slot++;
					below = (slot != 0) ? prefix_sum[slot - 1] : '0;
					picked_weight[draws_held] = WEIGHT_BITS'(prefix_sum[slot] - below);
					picked_sum += SUM_BITS'(prefix_sum[slot] - below);
					draws_held++;
					res.idx = slot[OUT_IDX_BITS-1:0];
				end
			end
			OP_READ: begin
				if (pos >= draws_held) begin
					res.st = ST_FULL;
				end else if (picked_sum == 0) begin
					res.st = ST_ZERO;
				end else begin
					quot = (64'(picked_weight[pos]) * FULL_SCALE) / 64'(picked_sum);
					res.norm = (quot > FULL_SCALE) ? NORM_BITS'(FULL_SCALE) : quot[NORM_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Weights lean toward the corners: zero, full scale and tiny values.
	function automatic logic [IN_WT_BITS-1:0] random_weight();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		if (roll == 2)
			return IN_WT_BITS'($urandom_range(0, 15));
		return IN_WT_BITS'($urandom);
	endfunction

	function automatic logic [RAND_BITS-1:0] random_draw();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return RAND_BITS'($urandom);
	endfunction

	// Mostly a slot that has been drawn, now and then any slot at all.
	function automatic logic [POS_BITS-1:0] random_slot();
		if (draws_held != 0 && $urandom_range(0, 4) != 0)
			return POS_BITS'($urandom_range(0, draws_held - 1));
		return POS_BITS'($urandom);
	endfunction

	// Offers one request and waits for the unit to take it. The sender works
	// in bursts: at the start of a burst it may drop valid for a random gap.
	// Until the drain, valid is only lowered here, before the new request is raised, so valid
	// never gets two assignments in one time step.
	task automatic issue(op_t op, logic [IN_WT_BITS-1:0] weight, logic [RAND_BITS-1:0] rnd,
			logic [POS_BITS-1:0] pos, logic hand_checked, outcome_t hand_want);
		int gap;
		outcome_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		operation <= op;
		weight_in <= weight;
		random_value <= rnd;
		position <= pos;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		// Taken at this edge: record what the unit now owes.
		predicted = predict_resample(op, weight, rnd, pos);
		pending_outcomes.push_back(hand_checked ? hand_want : predicted);
		requests_taken++;
		if (op != OP_SPARE)
			useful_sent++;
	endtask

	// Directed plan. Rows with a hand-written result are the easy ones: empty
	// tables, undrawn slots, a zero sum, the spare opcode, a lone draw read at
	// full scale and loads slotted by order. The rest go through the predictor.
	plan_row_t directed_plan [PLAN_ROWS] = '{
		// Draw and read on an empty unit, then the spare opcode with all ones.
		'{OP_DRAW,  16'h0000, 16'hffff, 8'h00, 1'b1, '{8'd0, 16'd0, ST_ZERO}},
		'{OP_READ,  16'h0000, 16'h0000, 8'h00, 1'b1, '{8'd0, 16'd0, ST_FULL}},
		'{OP_SPARE, 16'hffff, 16'hffff, 8'hff, 1'b1, '{8'd0, 16'd0, ST_OK}},
		// A zero weight gives a zero total; the failed draw keeps the set open.
		'{OP_LOAD,  16'h0000, 16'h0000, 8'h00, 1'b1, '{8'd0, 16'd0, ST_OK}},
		'{OP_DRAW,  16'h0000, 16'hffff, 8'h00, 1'b1, '{8'd0, 16'd0, ST_ZERO}},
		'{OP_LOAD,  16'hffff, 16'h0000, 8'h00, 1'b1, '{8'd1, 16'd0, ST_OK}},
		'{OP_LOAD,  16'h0001, 16'h0000, 8'h00, 1'b1, '{8'd2, 16'd0, ST_OK}},
		// The lowest draw lands on the zero-weight particle, so the sum is zero.
		'{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 1'b0, FROM_MODEL},
		'{OP_READ,  16'h0000, 16'h0000, 8'h00, 1'b1, '{8'd0, 16'd0, ST_ZERO}},
		'{OP_DRAW,  16'h0000, 16'hffff, 8'h00, 1'b0, FROM_MODEL},
		'{OP_DRAW,  16'h0000, 16'h8000, 8'h00, 1'b0, FROM_MODEL},
		'{OP_READ,  16'h0000, 16'h0000, 8'h00, 1'b0, FROM_MODEL},
		'{OP_READ,  16'h0000, 16'h0000, 8'h02, 1'b0, FROM_MODEL},
		'{OP_READ,  16'h0000, 16'h0000, 8'h03, 1'b1, '{8'd0, 16'd0, ST_FULL}},
		'{OP_READ,  16'h0000, 16'h0000, 8'hff, 1'b1, '{8'd0, 16'd0, ST_FULL}},
		// A load after draws starts a new set. One draw makes up the whole
		// sum, so its normalized weight is full scale.
		'{OP_LOAD,  16'hffff, 16'h0000, 8'h00, 1'b1, '{8'd0, 16'd0, ST_OK}},
		'{OP_DRAW,  16'h0000, 16'h0001, 8'h00, 1'b0, FROM_MODEL},
		'{OP_READ,  16'h0000, 16'h0000, 8'h00, 1'b1, '{8'd0, 16'hffff, ST_OK}},
		'{OP_SPARE, 16'h0000, 16'h0000, 8'h00, 1'b1, '{8'd0, 16'd0, ST_OK}},
		// Trailing zero weights: the top draw must stop at the first particle.
		'{OP_LOAD,  16'h000c, 16'h0000, 8'h00, 1'b1, '{8'd0, 16'd0, ST_OK}},
		'{OP_LOAD,  16'h0000, 16'h0000, 8'h00, 1'b1, '{8'd1, 16'd0, ST_OK}},
		'{OP_LOAD,  16'h0000, 16'h0000, 8'h00, 1'b1, '{8'd2, 16'd0, ST_OK}},
		'{OP_DRAW,  16'h0000, 16'hffff, 8'h00, 1'b0, FROM_MODEL},
		'{OP_READ,  16'h0000, 16'h0000, 8'h00, 1'b0, FROM_MODEL}
	};

	// Sender: reset, the directed plan, then random traffic, then the drain.
	initial begin
		int kind;
		int n_loads;
		int n_draws;
		int n_reads;
		bit full_set_done;
		full_set_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i])
			issue(directed_plan[i].op, directed_plan[i].weight, directed_plan[i].rnd,
				directed_plan[i].pos, directed_plan[i].hand_checked, directed_plan[i].want);

		while (useful_sent < USEFUL_TARGET) begin
			kind = $urandom_range(0, 9);
			if (!full_set_done && useful_sent >= 150) begin
				// One set past capacity: the extra loads and draws must be refused
				// as full, and reads reach the last slot.
				full_set_done = 1'b1;
				n_loads = PARTICLE_COUNT + $urandom_range(1, 3);
				n_draws = PARTICLE_COUNT + $urandom_range(1, 3);
				repeat (n_loads)
					issue(OP_LOAD, IN_WT_BITS'($urandom_range(1, 65535)), '0,
						POS_BITS'($urandom), 1'b0, FROM_MODEL);
				repeat (n_draws)
					issue(OP_DRAW, '0, random_draw(), POS_BITS'($urandom), 1'b0, FROM_MODEL);
				issue(OP_READ, '0, '0, '1, 1'b0, FROM_MODEL);
				repeat (12)
					issue(OP_READ, '0, '0, random_slot(), 1'b0, FROM_MODEL);
			end else if (kind < 7) begin
				// A well-formed small set: loads, then draws and reads mixed.
				n_loads = $urandom_range(1, 12);
				n_draws = $urandom_range(1, 16);
				n_reads = $urandom_range(1, 8);
				repeat (n_loads)
					issue(OP_LOAD, random_weight(), RAND_BITS'($urandom),
						POS_BITS'($urandom), 1'b0, FROM_MODEL);
				while (n_draws + n_reads > 0) begin
					if (n_reads == 0 || (n_draws > 0 && $urandom_range(0, 2) != 0)) begin
						issue(OP_DRAW, IN_WT_BITS'($urandom), random_draw(),
							POS_BITS'($urandom), 1'b0, FROM_MODEL);
						n_draws--;
					end else begin
						issue(OP_READ, IN_WT_BITS'($urandom), RAND_BITS'($urandom),
							random_slot(), 1'b0, FROM_MODEL);
						n_reads--;
					end
				end
			end else begin
				// Noise: any opcode, any field values.
				repeat ($urandom_range(1, 10))
					issue(op_t'($urandom_range(0, 3)), IN_WT_BITS'($urandom),
						RAND_BITS'($urandom), POS_BITS'($urandom), 1'b0, FROM_MODEL);
			end
		end

		// Everything is sent. Wait for the owed results, then give the unit a
		// few times its longest request time to show any stray result.
		item_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_multinomial_resampler_unit OK");
		else
			$display("tb_multinomial_resampler_unit NOT OK");
		$finish;
	end

	// Receiver: stall patterns that change after each random span. Once, after
	// enough requests have gone in, it holds off for a long stretch so that
	// the output register and the unit fill and the input gets stalled.
	initial begin
		int mode;
		int span;
		int tick;
		bit held_off;
		held_off = 1'b0;
		tick = 0;
		wait (arst_n);
		forever begin
			if (!held_off && requests_taken >= HOLD_OFF_AT) begin
				held_off = 1'b1;
				repeat (HOLD_OFF_CYCLES) begin
					@(posedge clk);
					result_stall <= 1'b1;
				end
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(5, 60);
				repeat (span) begin
					@(posedge clk);
					tick++;
					case (mode)
						0: result_stall <= 1'b0;
						1: result_stall <= ($urandom_range(0, 3) == 0);
						2: result_stall <= 1'($urandom_range(0, 1));
						default: result_stall <= (tick % 5 < 3);
					endcase
				end
			end
		end
	end

	// Result checker: each accepted result is compared with the oldest owed one.
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_outcomes.size() == 0) begin
				$error("unexpected result: source_index %0d normalized_weight %0d status %0d",
					source_index, normalized_weight, status);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (source_index !== want.idx) begin
					$error("source_index: expected %0d, actual %0d", want.idx, source_index);
					fail_count++;
				end
				if (normalized_weight !== want.norm) begin
					$error("normalized_weight: expected %0d, actual %0d",
						want.norm, normalized_weight);
					fail_count++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: ends the run if neither side moves anything for too long. The
	// limit covers the long receiver hold-off plus the slowest request.
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_multinomial_resampler_unit NOT OK");
				$finish;
			end
		end
	end

endmodule
